/* design/csc_pkg.sv */
// Shared types and constants of the conductivity sample conditioner.
package csc_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int ACC_W           = 88;
   localparam int CNT_W           = 7;
   localparam int STATE_W         = 48;
   localparam int COND_W          = 40;
   localparam int RES_W           = 30;
   localparam int WEIGHT_W        = 16;
   localparam int CELL_W          = 24;
   localparam int TEMP_W          = 15;
   localparam int LOOP_W          = 15;
   localparam int FAULT_W         = 2;
   localparam int CSR_INDEX_W     = 3;

   localparam logic [54:0] SCALE_NUM        = 55'd30000000000000000;
   localparam int          DRIVE_OFFSET_UV  = 20000;
   localparam int          COMP_BIAS        = 2500;
   localparam logic [15:0] WEIGHT_ONE       = 16'd32768;
   localparam logic [15:0] WEIGHT_DEFAULT   = 16'd9830;
   localparam logic [39:0] SPAN_FALLBACK_HI = 40'd10000000;
   localparam logic [13:0] LOOP_SPAN_UA     = 14'd16000;
   localparam logic [14:0] LOOP_ZERO_UA     = 15'd4000;
   localparam logic [14:0] LOOP_MAX_UA      = 15'd24000;
   localparam logic [14:0] LOOP_TOP_UA      = 15'd20000;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_DRIVE = 2'd1,
      FAULT_COMP  = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      CSR_RES_A  = 3'd0,
      CSR_RES_B  = 3'd1,
      CSR_RES_C  = 3'd2,
      CSR_RES_D  = 3'd3,
      CSR_WEIGHT = 3'd4,
      CSR_CELL   = 3'd5,
      CSR_SPAN_LO = 3'd6,
      CSR_SPAN_HI = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_N,
      ST_MUL_RD,
      ST_MUL_DC,
      ST_DIV_C,
      ST_SMOOTH,
      ST_POST,
      ST_KMUL,
      ST_LSET,
      ST_LMUL,
      ST_DIV_L,
      ST_DONE
   } state_type;

endpackage

/* design/csc_if.sv */
// Item channel interfaces for measurement requests and conditioned results.
interface csc_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] current_sense_uv;
   logic signed [SAMPLE_BITS-1:0] drive_voltage_uv;
   logic [1:0]                    range_select;
   logic signed [14:0]            temperature_centi;

   modport source (output valid, current_sense_uv, drive_voltage_uv, range_select,
                   temperature_centi, input ready);
   modport sink (input valid, current_sense_uv, drive_voltage_uv, range_select,
                 temperature_centi, output ready);
endinterface

interface csc_rsp_if;
   logic        valid;
   logic        ready;
   logic [39:0] conductance;
   logic [14:0] loop_current_ua;
   logic [1:0]  fault;

   modport source (output valid, conductance, loop_current_ua, fault, input ready);
   modport sink (input valid, conductance, loop_current_ua, fault, output ready);
endinterface

/* design/conductivity_sample_conditioner.sv */
// Conductivity sample conditioner: one measurement item in, one conditioned result item out.
//
// The req_chan channel takes one measurement item: sense and drive voltages, range index
// and temperature. The rsp_chan channel returns one item per measurement with the
// conductance, the loop current (4-20 mA over the span, clamped to 0-24 mA) and a fault
// code. Registers are written through csr_we, csr_index and csr_wdata; the user must
// write them only while the block is idle, as the block itself does not enforce this.
// Items are processed one at a time by a single bit-serial multiplier and a restoring
// divider that retires one quotient bit per cycle. A faulted item goes from the check
// state straight to the result; for a good item the two 88-step divisions dominate.
// The first sample skips smoothing, and a smoothed value that is not positive skips
// the cell constant multiply.
// The result stays in an output register until the receiver takes it; while it waits,
// no new item is accepted. After the result is taken the block returns to idle, where
// the next item can be accepted, so a new item is taken only after the last result.
// Reset restores all configuration registers to their defaults, clears the smoothing
// history and marks the next item as the first sample.
module conductivity_sample_conditioner #(
   parameter int SAMPLE_BITS = csc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   csc_req_if.sink                           req_chan,
   csc_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [csc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csc_pkg::COND_W-1:0]        csr_wdata
);
   import csc_pkg::*;

   localparam int MB_W = (SAMPLE_BITS + 1 > CELL_W) ? SAMPLE_BITS + 1 : CELL_W;
   localparam int AW   = ACC_W;

   state_type state_ff, state_in;

   logic [RES_W-1:0]    res_ff [4];
   logic [WEIGHT_W-1:0] weight_ff;
   logic [CELL_W-1:0]   cell_ff;
   logic [COND_W-1:0]   span_lo_ff, span_hi_ff;

   logic signed [SAMPLE_BITS-1:0] vi_ff;
   logic signed [SAMPLE_BITS:0]   d_ff;
   logic signed [15:0]            comp_ff;
   logic [1:0]                    rsel_ff;
   logic                          neg_ff;
   logic                          first_ff;
   logic signed [STATE_W-1:0]     prev_ff, c_ff;
   logic [COND_W-1:0]             g_ff;
   logic [LOOP_W-1:0]             cur_ff;
   fault_type                     fault_ff;

   logic [AW-1:0]    acc_ff, ma_ff, num_ff, den_ff, rem_ff;
   logic [MB_W-1:0]  mb_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [AW:0]                 div_t;
   logic                        div_ge;
   logic [AW-1:0]               div_rem;
   logic [SAMPLE_BITS-1:0]      av;
   logic [SAMPLE_BITS:0]        ad;
   logic [RES_W-1:0]            r_sel;
   logic signed [STATE_W-1:0]   c_sat;
   logic signed [STATE_W:0]     c_diff;
   logic [AW-1:0]               k_prod;
   logic signed [COND_W:0]      l_diff, l_span;
   logic [LOOP_W-1:0]           cur_val;
   logic                        cnt_zero;

   assign cnt_zero = (cnt_ff == '0);
   assign div_t    = {rem_ff, num_ff[AW-1]};
   assign div_ge   = (div_t >= {1'b0, den_ff});
   assign div_rem  = div_ge ? AW'(div_t - {1'b0, den_ff}) : div_t[AW-1:0];
   assign av       = vi_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-vi_ff) : SAMPLE_BITS'(vi_ff);
   assign ad       = d_ff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_ff) : (SAMPLE_BITS+1)'(d_ff);
   assign r_sel    = (res_ff[rsel_ff] == '0) ? RES_W'(1) : res_ff[rsel_ff];
   assign c_diff   = {c_sat[STATE_W-1], c_sat} - {prev_ff[STATE_W-1], prev_ff};
   assign k_prod   = acc_ff >> 16;
   assign l_diff   = $signed({1'b0, g_ff}) - $signed({1'b0, span_lo_ff});
   assign l_span   = $signed({1'b0, span_hi_ff}) - $signed({1'b0, span_lo_ff});

   always_comb begin
      if (neg_ff) begin
         if ((|num_ff[AW-1:STATE_W]) || (num_ff[STATE_W-1] && (|num_ff[STATE_W-2:0]))) begin
            c_sat = {1'b1, {(STATE_W-1){1'b0}}};
         end else begin
            c_sat = STATE_W'(-num_ff[STATE_W-1:0]);
         end
      end else begin
         if (|num_ff[AW-1:STATE_W-1]) begin
            c_sat = {1'b0, {(STATE_W-1){1'b1}}};
         end else begin
            c_sat = STATE_W'(num_ff[STATE_W-1:0]);
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if ((|num_ff[AW-1:LOOP_W]) || (num_ff[LOOP_W-1:0] >= LOOP_ZERO_UA)) begin
            cur_val = '0;
         end else begin
            cur_val = LOOP_ZERO_UA - num_ff[LOOP_W-1:0];
         end
      end else begin
         if ((|num_ff[AW-1:LOOP_W]) || (num_ff[LOOP_W-1:0] > LOOP_TOP_UA)) begin
            cur_val = LOOP_MAX_UA;
         end else begin
            cur_val = LOOP_ZERO_UA + num_ff[LOOP_W-1:0];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (d_ff == '0 || comp_ff <= 0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_N;
            end
         end
         ST_MUL_N:  if (cnt_zero) state_in = ST_MUL_RD;
         ST_MUL_RD: if (cnt_zero) state_in = ST_MUL_DC;
         ST_MUL_DC: if (cnt_zero) state_in = ST_DIV_C;
         ST_DIV_C: begin
            if (cnt_zero) begin
               state_in = first_ff ? ST_POST : ST_SMOOTH;
            end
         end
         ST_SMOOTH: if (cnt_zero) state_in = ST_POST;
         ST_POST: begin
            state_in = (c_ff <= 0) ? ST_LSET : ST_KMUL;
         end
         ST_KMUL:  if (cnt_zero) state_in = ST_LSET;
         ST_LSET:  state_in = ST_LMUL;
         ST_LMUL:  if (cnt_zero) state_in = ST_DIV_L;
         ST_DIV_L: if (cnt_zero) state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready           = (state_ff == ST_IDLE);
      rsp_chan.valid           = (state_ff == ST_DONE);
      rsp_chan.conductance     = g_ff;
      rsp_chan.loop_current_ua = cur_ff;
      rsp_chan.fault           = fault_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         res_ff[0]  <= RES_W'(1000000);
         res_ff[1]  <= RES_W'(1000000);
         res_ff[2]  <= RES_W'(1000000);
         res_ff[3]  <= RES_W'(1000000);
         weight_ff  <= WEIGHT_DEFAULT;
         cell_ff    <= CELL_W'(65536);
         span_lo_ff <= '0;
         span_hi_ff <= SPAN_FALLBACK_HI;
         prev_ff    <= '0;
         first_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_RES_A:   res_ff[0]  <= csr_wdata[RES_W-1:0];
               CSR_RES_B:   res_ff[1]  <= csr_wdata[RES_W-1:0];
               CSR_RES_C:   res_ff[2]  <= csr_wdata[RES_W-1:0];
               CSR_RES_D:   res_ff[3]  <= csr_wdata[RES_W-1:0];
               CSR_WEIGHT:  weight_ff  <= csr_wdata[WEIGHT_W-1:0];
               CSR_CELL:    cell_ff    <= csr_wdata[CELL_W-1:0];
               CSR_SPAN_LO: span_lo_ff <= csr_wdata;
               CSR_SPAN_HI: span_hi_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_CHECK) begin
            if (weight_ff == '0 || weight_ff > WEIGHT_ONE) begin
               weight_ff <= WEIGHT_DEFAULT;
            end
            if (span_lo_ff == span_hi_ff) begin
               span_lo_ff <= '0;
               span_hi_ff <= SPAN_FALLBACK_HI;
            end
         end
         if (state_ff == ST_DIV_C && cnt_zero && first_ff) begin
            first_ff <= 1'b0;
         end
         if (state_ff == ST_POST) begin
            prev_ff <= c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff != ST_IDLE && state_ff != ST_POST && state_ff != ST_LSET && !cnt_zero) begin
         acc_ff <= acc_ff + (mb_ff[0] ? ma_ff : '0);
         ma_ff  <= ma_ff << 1;
         mb_ff  <= mb_ff >> 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if ((state_ff == ST_DIV_C || state_ff == ST_DIV_L) && !cnt_zero) begin
         rem_ff <= div_rem;
         num_ff <= {num_ff[AW-2:0], div_ge};
      end
      unique case (state_ff)
         ST_IDLE: begin
            cnt_ff  <= '0;
            vi_ff   <= req_chan.current_sense_uv;
            d_ff    <= $signed({req_chan.drive_voltage_uv[SAMPLE_BITS-1],
                                req_chan.drive_voltage_uv})
                       - $signed((SAMPLE_BITS+1)'(DRIVE_OFFSET_UV));
            comp_ff <= $signed({req_chan.temperature_centi[TEMP_W-1],
                                req_chan.temperature_centi}) + $signed(16'(COMP_BIAS));
            rsel_ff <= req_chan.range_select;
         end
         ST_CHECK: begin
            neg_ff <= vi_ff[SAMPLE_BITS-1] ^ d_ff[SAMPLE_BITS];
            g_ff   <= '0;
            cur_ff <= '0;
            if (d_ff == '0) begin
               fault_ff <= FAULT_DRIVE;
            end else if (comp_ff <= 0) begin
               fault_ff <= FAULT_COMP;
            end else begin
               fault_ff <= FAULT_NONE;
            end
            acc_ff <= '0;
            ma_ff  <= AW'(SCALE_NUM);
            mb_ff  <= MB_W'(av);
            cnt_ff <= CNT_W'(SAMPLE_BITS);
         end
         ST_MUL_N: begin
            if (cnt_zero) begin
               num_ff <= acc_ff;
               acc_ff <= '0;
               ma_ff  <= AW'(r_sel);
               mb_ff  <= MB_W'(ad);
               cnt_ff <= CNT_W'(SAMPLE_BITS + 1);
            end
         end
         ST_MUL_RD: begin
            if (cnt_zero) begin
               ma_ff  <= acc_ff;
               acc_ff <= '0;
               mb_ff  <= MB_W'(comp_ff[14:0]);
               cnt_ff <= CNT_W'(15);
            end
         end
         ST_MUL_DC: begin
            if (cnt_zero) begin
               den_ff <= acc_ff;
               rem_ff <= '0;
               cnt_ff <= CNT_W'(AW);
            end
         end
         ST_DIV_C: begin
            if (cnt_zero) begin
               c_ff   <= c_sat;
               acc_ff <= {{(AW-STATE_W){prev_ff[STATE_W-1]}}, prev_ff} << 15;
               ma_ff  <= AW'(signed'(c_diff));
               mb_ff  <= MB_W'(weight_ff);
               cnt_ff <= CNT_W'(WEIGHT_W);
            end
         end
         ST_SMOOTH: begin
            if (cnt_zero) begin
               c_ff <= acc_ff[STATE_W+14:15];
            end
         end
         ST_POST: begin
            g_ff   <= '0;
            acc_ff <= '0;
            ma_ff  <= AW'(c_ff[STATE_W-2:0]);
            mb_ff  <= MB_W'(cell_ff);
            cnt_ff <= CNT_W'(CELL_W);
         end
         ST_KMUL: begin
            if (cnt_zero) begin
               g_ff <= (|k_prod[AW-1:COND_W]) ? '1 : k_prod[COND_W-1:0];
            end
         end
         ST_LSET: begin
            neg_ff <= l_diff[COND_W] ^ l_span[COND_W];
            acc_ff <= '0;
            ma_ff  <= AW'(l_diff[COND_W] ? (COND_W+1)'(-l_diff) : (COND_W+1)'(l_diff));
            mb_ff  <= MB_W'(LOOP_SPAN_UA);
            den_ff <= AW'(l_span[COND_W] ? (COND_W+1)'(-l_span) : (COND_W+1)'(l_span));
            cnt_ff <= CNT_W'(14);
         end
         ST_LMUL: begin
            if (cnt_zero) begin
               num_ff <= acc_ff;
               rem_ff <= '0;
               cnt_ff <= CNT_W'(AW);
            end
         end
         ST_DIV_L: begin
            if (cnt_zero) begin
               cur_ff <= cur_val;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

endmodule

/* design/csc_checker.sv */
// Port-level checks of the conductivity sample conditioner and their binding.
module csc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [39:0] conductance,
   input logic [14:0] loop_current_ua,
   input logic [1:0]  fault
);
   import csc_pkg::*;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("An item was offered while a result item was pending.");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("A result item appeared in the cycle after acceptance.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(conductance)))
      else $error("A stalled result item changed.");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && fault != FAULT_NONE) |-> (conductance == '0 && loop_current_ua == '0))
      else $error("A faulted item carried nonzero outputs.");

   a_loop_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (loop_current_ua <= LOOP_MAX_UA))
      else $error("Loop current exceeded its limit.");

endmodule

bind conductivity_sample_conditioner csc_checker u_csc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .conductance     (rsp_chan.conductance),
   .loop_current_ua (rsp_chan.loop_current_ua),
   .fault           (rsp_chan.fault)
);
